@@ hdl/skm_pkg.sv @@
package skm_pkg;

    // geometry and fixed field widths
    localparam int KEY_CODES_DEF = 256;
    localparam int EVDEV_OFFSET  = 8;
    localparam int CHAR_W        = 21;
    localparam int SCAN_W        = 9;
    localparam int KEYREG_W      = 9;
    localparam int NUM_LEVELS    = 3;
    localparam int OP_W          = 3;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 9;
    localparam int S_TDATA_W     = 40;
    localparam int M_TDATA_W     = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PROFILE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_TAP = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_KEY  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ALT_KEY    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SYM_KEY    = 3'd4;

    // sticky level slots
    localparam logic [1:0] LV_SHIFT = 2'd0;
    localparam logic [1:0] LV_ALT   = 2'd1;
    localparam logic [1:0] LV_SYM   = 2'd2;

    // character table levels
    localparam logic [1:0] TL_BASE  = 2'd0;
    localparam logic [1:0] TL_SHIFT = 2'd1;
    localparam logic [1:0] TL_ALT   = 2'd2;
    localparam logic [1:0] TL_SYM   = 2'd3;

    // per level flag bits
    localparam logic [2:0] FLAG_NONE   = 3'b000;
    localparam logic [2:0] FLAG_LOCK   = 3'b001;
    localparam logic [2:0] FLAG_UNLOCK = 3'b010;
    localparam logic [2:0] FLAG_USED   = 3'b100;

    typedef enum logic [OP_W-1:0] {
        OP_PRESS   = 3'd0,
        OP_RELEASE = 3'd1,
        OP_SPEND   = 3'd2,
        OP_CLEAR   = 3'd3,
        OP_WRITE   = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        MODE_OFF     = 2'd0,
        MODE_HELD    = 2'd1,
        MODE_LATCHED = 2'd2,
        MODE_LOCKED  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_NONE     = 2'd0,
        ST_CONSUMED = 2'd1,
        ST_TEXT     = 2'd2
    } stat_t;

    // command to the level key unit, applied at the clock edge
    typedef struct packed {
        logic       key_dn;
        logic       key_up;
        logic [1:0] idx;
        logic       spend_shift;
        logic       spend_alt_sym;
        logic       clear;
    } lvl_cmd_t;

endpackage

@@ hdl/skm_ram.sv @@
module skm_ram
    import skm_pkg::*;
#(
    parameter int WIDTH = CHAR_W,
    parameter int DEPTH = KEY_CODES_DEF
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // read-first: a read of the address being written returns old data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rd_data_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rd_data_reg;

endmodule

@@ hdl/skm_levels.sv @@
module skm_levels
    import skm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     lock_on_double_tap,
    input  lvl_cmd_t cmd,
    output mode_t    mode[NUM_LEVELS],
    output mode_t    mode_next[NUM_LEVELS]
);

    mode_t      mode_reg[NUM_LEVELS];
    logic [2:0] flags_reg[NUM_LEVELS];
    logic [2:0] flags_next[NUM_LEVELS];

    always_comb
    begin
        for (int i = 0; i < NUM_LEVELS; i++)
        begin
            mode_next[i]  = mode_reg[i];
            flags_next[i] = flags_reg[i];
            if (cmd.clear)
            begin
                mode_next[i]  = MODE_OFF;
                flags_next[i] = FLAG_NONE;
            end
            else if (cmd.key_dn && cmd.idx == 2'(i))
            begin
                case (mode_reg[i])
                    MODE_HELD:
                    begin
                    end
                    MODE_LATCHED:
                    begin
                        mode_next[i]  = MODE_HELD;
                        flags_next[i] = lock_on_double_tap ? FLAG_LOCK : FLAG_NONE;
                    end
                    MODE_LOCKED:
                    begin
                        mode_next[i]  = MODE_HELD;
                        flags_next[i] = FLAG_UNLOCK;
                    end
                    default:
                    begin
                        mode_next[i]  = MODE_HELD;
                        flags_next[i] = FLAG_NONE;
                    end
                endcase
            end
            else if (cmd.key_up && cmd.idx == 2'(i))
            begin
                if (mode_reg[i] == MODE_HELD)
                begin
                    if ((flags_reg[i] & (FLAG_USED | FLAG_UNLOCK)) != FLAG_NONE)
                    begin
                        mode_next[i] = MODE_OFF;
                    end
                    else if ((flags_reg[i] & FLAG_LOCK) != FLAG_NONE)
                    begin
                        mode_next[i] = MODE_LOCKED;
                    end
                    else
                    begin
                        mode_next[i] = MODE_LATCHED;
                    end
                    flags_next[i] = FLAG_NONE;
                end
            end
            else if ((cmd.spend_shift && 2'(i) == LV_SHIFT) ||
                     (cmd.spend_alt_sym && 2'(i) != LV_SHIFT))
            begin
                // held: mark used; latched: the latch is spent
                if (mode_reg[i] == MODE_HELD)
                begin
                    flags_next[i] = flags_reg[i] | FLAG_USED;
                end
                else if (mode_reg[i] == MODE_LATCHED)
                begin
                    mode_next[i] = MODE_OFF;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LEVELS; i++)
            begin
                mode_reg[i]  <= MODE_OFF;
                flags_reg[i] <= FLAG_NONE;
            end
        end
        else
        begin
            mode_reg  <= mode_next;
            flags_reg <= flags_next;
        end
    end

    assign mode = mode_reg;

endmodule

@@ hdl/sticky_level_key_mapper.sv @@
// channel   | dir | signals                          | contents
// s_axis    | in  | tvalid tready tdata[39:0] tuser  | one key event or table operation
// m_axis    | out | tvalid tready tdata[31:0] tuser  | one result per item
// cfg       | in  | cfg_we cfg_index cfg_wdata       | register write, no read-back
//
// each item passes through the read stage (table and pressed-key rams,
// registered read) and the update stage, then sits in the output register
// sustained rate is one item per cycle while m_axis_tready stays high
// after reset the character table is swept to zero, all 4*KEY_CODES entries
// (1024 at the default), with s_axis_tready low; cfg writes are taken meanwhile
// a stalled output holds the update stage, which holds the input side
module sticky_level_key_mapper
    import skm_pkg::*;
#(
    parameter int KEY_CODES = KEY_CODES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,  // scan_code, shift_held, table_level, table_char
    input  logic [OP_W-1:0]       s_axis_tuser,  // operation
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]  m_axis_tdata,  // char_code, alt_active, alt_locked,
                                                 // sym_active, sym_locked, shift_latch_active,
                                                 // owns_alt_modifier, level_changed
    output logic [1:0]            m_axis_tuser,  // status
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int CW       = $clog2(KEY_CODES);
    localparam int CM_DEPTH = 4 * KEY_CODES;
    localparam int AW       = $clog2(CM_DEPTH);

    // configuration registers
    logic                profile_reg;
    logic                double_tap_reg;
    logic [KEYREG_W-1:0] shift_key_reg;
    logic [KEYREG_W-1:0] alt_key_reg;
    logic [KEYREG_W-1:0] sym_key_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            profile_reg    <= 1'b0;
            double_tap_reg <= 1'b1;
            shift_key_reg  <= 9'd256;
            alt_key_reg    <= 9'd256;
            sym_key_reg    <= 9'd256;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PROFILE:    profile_reg    <= cfg_wdata[0];
                REG_DOUBLE_TAP: double_tap_reg <= cfg_wdata[0];
                REG_SHIFT_KEY:  shift_key_reg  <= cfg_wdata;
                REG_ALT_KEY:    alt_key_reg    <= cfg_wdata;
                REG_SYM_KEY:    sym_key_reg    <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    // a key register at or above KEY_CODES means no such key
    logic shift_cfg, alt_cfg, sym_cfg;
    assign shift_cfg = 32'(shift_key_reg) < 32'(KEY_CODES);
    assign alt_cfg   = 32'(alt_key_reg) < 32'(KEY_CODES);
    assign sym_cfg   = 32'(sym_key_reg) < 32'(KEY_CODES);

    // pipeline control
    logic s1_valid_reg;
    logic s1_fire;
    logic in_fire;
    logic out_valid_reg;
    logic clr_busy_reg;
    logic [AW-1:0] clr_addr_reg;

    assign s1_fire       = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !clr_busy_reg && (!s1_valid_reg || s1_fire);
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // level key unit
    lvl_cmd_t cmd;
    mode_t    mode[NUM_LEVELS];
    mode_t    mode_next[NUM_LEVELS];

    skm_levels u_levels
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .lock_on_double_tap (double_tap_reg),
        .cmd                (cmd),
        .mode               (mode),
        .mode_next          (mode_next)
    );

    // input unpacking and key decode
    op_t               in_op;
    logic [SCAN_W-1:0] in_scan;
    logic              in_shift_held;
    logic [1:0]        in_tlevel;
    logic [CHAR_W-1:0] in_tchar;
    logic [SCAN_W:0]   in_key_wide;
    logic              in_key_ok;
    logic [CW-1:0]     in_code;
    logic [1:0]        in_lvl;

    assign in_op         = op_t'(s_axis_tuser);
    assign in_scan       = s_axis_tdata[8:0];
    assign in_shift_held = s_axis_tdata[9];
    assign in_tlevel     = s_axis_tdata[11:10];
    assign in_tchar      = s_axis_tdata[32:12];
    assign in_key_wide   = {1'b0, in_scan} - (SCAN_W+1)'(EVDEV_OFFSET);
    assign in_key_ok     = (in_scan >= SCAN_W'(EVDEV_OFFSET)) &&
                           (32'(in_key_wide) < 32'(KEY_CODES));
    assign in_code       = in_key_ok ? CW'(in_key_wide) : '0;

    // table level as it stands once the item now in the update stage is done
    always_comb
    begin
        if (mode_next[LV_SYM] != MODE_OFF)
        begin
            in_lvl = TL_SYM;
        end
        else if (mode_next[LV_ALT] != MODE_OFF)
        begin
            in_lvl = TL_ALT;
        end
        else if (in_shift_held || mode_next[LV_SHIFT] != MODE_OFF)
        begin
            in_lvl = TL_SHIFT;
        end
        else
        begin
            in_lvl = TL_BASE;
        end
    end

    // rams
    logic [AW-1:0]     cm_raddr;
    logic [CHAR_W-1:0] cm_rdata;
    logic              cm_we;
    logic [AW-1:0]     cm_waddr;
    logic [CHAR_W-1:0] cm_wdata;
    logic              cm_we_st;
    logic [AW-1:0]     cm_waddr_st;
    logic [CHAR_W-1:0] ps_rdata;
    logic              ps_we;

    assign cm_raddr = AW'(in_lvl) * AW'(KEY_CODES) + AW'(in_code);
    assign cm_we    = clr_busy_reg || cm_we_st;
    assign cm_waddr = clr_busy_reg ? clr_addr_reg : cm_waddr_st;

    skm_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (CM_DEPTH)
    ) u_char_map (
        .clk   (clk),
        .we    (cm_we),
        .waddr (cm_waddr),
        .wdata (cm_wdata),
        .re    (in_fire),
        .raddr (cm_raddr),
        .rdata (cm_rdata)
    );

    // update stage registers
    op_t               s1_op_reg;
    logic [CW-1:0]     s1_code_reg;
    logic              s1_key_ok_reg;
    logic [1:0]        s1_lvl_reg;
    logic [1:0]        s1_tlevel_reg;
    logic [CHAR_W-1:0] s1_tchar_reg;
    logic              byp_c_reg;
    logic [CHAR_W-1:0] byp_c_data_reg;
    logic              byp_p_reg;
    logic [CHAR_W-1:0] byp_p_data_reg;
    logic [KEY_CODES-1:0] pvalid_reg;

    // forwarding of writes that collide with the read of the next item
    logic [CHAR_W-1:0] cdata;
    logic [CHAR_W-1:0] pdata;

    assign cdata = byp_c_reg ? byp_c_data_reg : cm_rdata;

    skm_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (KEY_CODES)
    ) u_pressed (
        .clk   (clk),
        .we    (ps_we),
        .waddr (s1_code_reg),
        .wdata (cdata),
        .re    (in_fire),
        .raddr (in_code),
        .rdata (ps_rdata)
    );

    assign pdata       = byp_p_reg ? byp_p_data_reg : ps_rdata;
    assign cm_waddr_st = AW'(s1_tlevel_reg) * AW'(KEY_CODES) + AW'(s1_code_reg);
    assign cm_wdata    = clr_busy_reg ? '0 : s1_tchar_reg;

    // update stage: decide the answer and the state changes
    stat_t             out_status_next;
    logic [CHAR_W-1:0] out_char_next;
    logic              changed;
    logic              pv_clr;
    logic              pv_clr_all;
    logic              key_act;
    logic              is_press;
    logic              shift_match;
    logic              alt_match;
    logic              sym_match;

    assign is_press    = (s1_op_reg == OP_PRESS);
    assign key_act     = (s1_op_reg == OP_PRESS || s1_op_reg == OP_RELEASE) &&
                         profile_reg && s1_key_ok_reg;
    assign shift_match = shift_cfg && (32'(shift_key_reg) == 32'(s1_code_reg));
    assign alt_match   = alt_cfg && (32'(alt_key_reg) == 32'(s1_code_reg));
    assign sym_match   = sym_cfg && (32'(sym_key_reg) == 32'(s1_code_reg));

    always_comb
    begin
        cmd             = '0;
        out_status_next = ST_NONE;
        out_char_next   = '0;
        changed         = 1'b0;
        cm_we_st        = 1'b0;
        ps_we           = 1'b0;
        pv_clr          = 1'b0;
        pv_clr_all      = 1'b0;
        if (key_act)
        begin
            if (shift_match)
            begin
                // shift key answers not handled
                cmd.key_dn = is_press;
                cmd.key_up = !is_press;
                cmd.idx    = LV_SHIFT;
                changed    = 1'b1;
            end
            else if (alt_match || sym_match)
            begin
                // alt wins when alt and sym share a code
                cmd.key_dn      = is_press;
                cmd.key_up      = !is_press;
                cmd.idx         = alt_match ? LV_ALT : LV_SYM;
                changed         = 1'b1;
                out_status_next = ST_CONSUMED;
            end
            else if (!is_press)
            begin
                if (pvalid_reg[s1_code_reg])
                begin
                    out_char_next   = pdata;
                    out_status_next = ST_TEXT;
                    pv_clr          = 1'b1;
                end
            end
            else
            begin
                if (s1_lvl_reg == TL_ALT || s1_lvl_reg == TL_SYM)
                begin
                    cmd.spend_alt_sym = 1'b1;
                    changed           = 1'b1;
                end
                if (cdata != '0)
                begin
                    ps_we           = 1'b1;
                    out_char_next   = cdata;
                    out_status_next = ST_TEXT;
                end
            end
        end
        else
        begin
            case (s1_op_reg)
                OP_SPEND:
                begin
                    cmd.spend_shift = 1'b1;
                    changed         = 1'b1;
                end
                OP_CLEAR:
                begin
                    changed    = (mode[LV_SHIFT] != MODE_OFF) ||
                                 (mode[LV_ALT] != MODE_OFF) ||
                                 (mode[LV_SYM] != MODE_OFF);
                    cmd.clear  = 1'b1;
                    pv_clr_all = 1'b1;
                end
                OP_WRITE:
                begin
                    cm_we_st = s1_key_ok_reg;
                end
                default:
                begin
                end
            endcase
        end
        // nothing commits unless the item moves on
        if (!s1_fire)
        begin
            cmd        = '0;
            cm_we_st   = 1'b0;
            ps_we      = 1'b0;
            pv_clr     = 1'b0;
            pv_clr_all = 1'b0;
        end
    end

    // status flags from the level state after this item
    logic [6:0] out_flags_next;

    assign out_flags_next[0] = mode_next[LV_ALT] != MODE_OFF;
    assign out_flags_next[1] = mode_next[LV_ALT] == MODE_LOCKED;
    assign out_flags_next[2] = mode_next[LV_SYM] != MODE_OFF;
    assign out_flags_next[3] = mode_next[LV_SYM] == MODE_LOCKED;
    assign out_flags_next[4] = profile_reg && shift_cfg &&
                               (mode_next[LV_SHIFT] == MODE_LATCHED ||
                                mode_next[LV_SHIFT] == MODE_LOCKED);
    assign out_flags_next[5] = profile_reg &&
                               ((alt_cfg && mode_next[LV_ALT] != MODE_OFF) ||
                                (sym_cfg && mode_next[LV_SYM] != MODE_OFF));
    assign out_flags_next[6] = changed;

    // stage control, table sweep and pressed-key valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            clr_busy_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            pvalid_reg    <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (clr_busy_reg)
            begin
                if (clr_addr_reg == AW'(CM_DEPTH - 1))
                begin
                    clr_busy_reg <= 1'b0;
                end
                else
                begin
                    clr_addr_reg <= clr_addr_reg + AW'(1);
                end
            end

            if (pv_clr_all)
            begin
                pvalid_reg <= '0;
            end
            else if (ps_we)
            begin
                pvalid_reg[s1_code_reg] <= 1'b1;
            end
            else if (pv_clr)
            begin
                pvalid_reg[s1_code_reg] <= 1'b0;
            end
        end
    end

    // payload registers
    stat_t             out_status_reg;
    logic [CHAR_W-1:0] out_char_reg;
    logic [6:0]        out_flags_reg;

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_op_reg      <= in_op;
            s1_code_reg    <= in_code;
            s1_key_ok_reg  <= in_key_ok;
            s1_lvl_reg     <= in_lvl;
            s1_tlevel_reg  <= in_tlevel;
            s1_tchar_reg   <= in_tchar;
            byp_c_reg      <= cm_we_st && (cm_waddr_st == cm_raddr);
            byp_c_data_reg <= s1_tchar_reg;
            byp_p_reg      <= ps_we && (s1_code_reg == in_code);
            byp_p_data_reg <= cdata;
        end
        if (s1_fire)
        begin
            out_status_reg <= out_status_next;
            out_char_reg   <= out_char_next;
            out_flags_reg  <= out_flags_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, out_flags_reg, out_char_reg};
    assign m_axis_tuser  = out_status_reg;

endmodule
